[design/sfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types, codes and reset values of the serial frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

  // header length default, also the reset value of the frame total
  localparam int HEADER_BYTES_DEFAULT = 4;

  // register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_START_BYTE    = 2'd0;
  localparam logic [1:0] REG_FRAME_LIMIT   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic [7:0]  START_BYTE_RESET    = 8'h55;
  localparam logic [8:0]  FRAME_LIMIT_RESET   = 9'd128;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd10000;

  // saturation point of the body tick counter
  localparam logic [16:0] TICK_MAX = 17'h1FFFF;

  // input word kind
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_START = 3'd1,
    ERR_TOO_LONG  = 3'd2,
    ERR_CHECKSUM  = 3'd3,
    ERR_TIMEOUT   = 3'd4
  } err_kind_t;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [8:0]  frame_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [8:0] byte_index;
    logic       byte_taken;
    logic       frame_end;
    logic       checksum_good;
    err_kind_t  error_kind;
    logic       wake_line;
  } result_t;

endpackage

[design/serial_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit
// length-prefixed frame receiver with xor checksum, echo of every byte and
// a body timeout driven by millisecond ticks
// ----------------------------------------------------------------------------
//  channel | handshake                        | payload
//  --------+----------------------------------+--------------------------------
//  in      | in_valid / in_stall              | action, rx_byte
//  out     | out_valid / out_stall            | byte_out, byte_index, byte_taken,
//          |                                  | frame_end, checksum_good,
//          |                                  | error_kind, wake_line
//  cfg     | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
//  one word in and one result word out per clock while out_stall is low; a
//  result shows on out_valid once its word has passed through the input
//  register, then decode and frame state update into the result register
//  the input register refills in the same cycle the result register is
//  freed, so a stall on the output only holds the input when both are full
//  reset (rst, synchronous) empties both registers, loads the register
//  reset values and puts the frame state in the header phase
// ----------------------------------------------------------------------------
module serial_frame_receiver_unit #(
  parameter int HEADER_BYTES = sfr_pkg::HEADER_BYTES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        action,
  input  logic [7:0]                  rx_byte,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  byte_out,
  output logic [8:0]                  byte_index,
  output logic                        byte_taken,
  output logic                        frame_end,
  output logic                        checksum_good,
  output logic [2:0]                  error_kind,
  output logic                        wake_line,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfr_pkg::PADDR_W-1:0] paddr,
  input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
  output logic [sfr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import sfr_pkg::*;

  cfg_t    cfg;
  result_t res;

  // input register
  logic       in_full;
  logic       action_q;
  logic [7:0] rx_byte_q;

  logic in_take;
  logic advance;

  // a word moves into the result register when that register is empty or drains
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_q  <= action;
      rx_byte_q <= rx_byte;
    end
  end

  sfr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // frame state advances exactly once per word, when it leaves the input register
  sfr_deframer #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_deframer (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .action  (action_q),
    .rx_byte (rx_byte_q),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_out      <= res.byte_out;
      byte_index    <= res.byte_index;
      byte_taken    <= res.byte_taken;
      frame_end     <= res.frame_end;
      checksum_good <= res.checksum_good;
      error_kind    <= res.error_kind;
      wake_line     <= res.wake_line;
    end
  end

  // a good checksum only on a clean frame end
  a_good_is_clean_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_good |-> frame_end && (error_kind == ERR_NONE))
    else $error("checksum_good without a clean frame end");

  // every frame end returns to waiting for a header
  a_end_wakes: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> wake_line && byte_taken)
    else $error("frame end left the body phase active");

  // a timeout comes only from a tick and drops back to header phase
  a_timeout_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_kind == ERR_TIMEOUT) |-> !byte_taken && wake_line)
    else $error("timeout on a byte word or without leaving the body");

  // no result appears without a word having been held in the input register
  a_out_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_full))
    else $error("result word without a pending input word");

endmodule

[design/sfr_apb_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_apb_regs
// apb register file: start byte, frame limit, body timeout
// ----------------------------------------------------------------------------
module sfr_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfr_pkg::PADDR_W-1:0] paddr,
  input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
  output logic [sfr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output sfr_pkg::cfg_t               cfg
);
  import sfr_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= START_BYTE_RESET;
      cfg.frame_limit   <= FRAME_LIMIT_RESET;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_START_BYTE:    cfg.start_byte    <= pwdata[7:0];
        REG_FRAME_LIMIT:   cfg.frame_limit   <= pwdata[8:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START_BYTE:    prdata = {{(PDATA_W-8){1'b0}}, cfg.start_byte};
      REG_FRAME_LIMIT:   prdata = {{(PDATA_W-9){1'b0}}, cfg.frame_limit};
      REG_TIMEOUT_TICKS: prdata = {{(PDATA_W-16){1'b0}}, cfg.timeout_ticks};
      default:           prdata = '0;
    endcase
  end

endmodule

[design/sfr_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_deframer
// frame state and single-pass per-word decode (header, body, checksum, timeout)
// ----------------------------------------------------------------------------
module sfr_deframer #(
  parameter int HEADER_BYTES = sfr_pkg::HEADER_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             action,
  input  logic [7:0]       rx_byte,
  input  sfr_pkg::cfg_t    cfg,
  output sfr_pkg::result_t res
);
  import sfr_pkg::*;

  localparam logic [8:0] HDR_LEN = 9'(HEADER_BYTES);

  phase_t      phase, phase_next;
  logic [8:0]  index_count, index_count_next;
  logic [8:0]  frame_total, frame_total_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [7:0]  length_byte, length_byte_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [16:0] tick_count, tick_count_next;

  logic        is_byte;
  logic        is_tick;
  logic [16:0] tick_inc;
  logic        timeout_hit;
  logic [8:0]  idx_inc;
  logic [7:0]  first_cur;
  logic [7:0]  len_cur;
  logic [8:0]  total;
  logic        hdr_done;
  logic        bad_start;
  logic        too_long;
  logic        last_byte;
  logic        sum_match;

  // per-word decode
  always_comb begin
    is_byte     = (action == ACT_BYTE);
    is_tick     = (action == ACT_TICK);
    tick_inc    = (tick_count == TICK_MAX) ? tick_count : tick_count + 17'd1;
    timeout_hit = is_tick && (phase == PH_BODY) && (tick_inc > {1'b0, cfg.timeout_ticks});
    idx_inc     = index_count + 9'd1;
    first_cur   = (index_count == 9'd0) ? rx_byte : first_byte;
    len_cur     = (index_count == 9'd1) ? rx_byte : length_byte;
    total       = {1'b0, len_cur} + HDR_LEN + 9'd1;
    hdr_done    = is_byte && (phase == PH_HEADER) && (idx_inc >= HDR_LEN);
    bad_start   = hdr_done && (first_cur != cfg.start_byte);
    too_long    = hdr_done && !bad_start && (total > cfg.frame_limit);
    last_byte   = is_byte && (phase == PH_BODY) && (idx_inc >= frame_total);
    sum_match   = (running_xor == rx_byte);
  end

  // next state
  always_comb begin
    phase_next       = phase;
    index_count_next = index_count;
    frame_total_next = frame_total;
    first_byte_next  = first_byte;
    length_byte_next = length_byte;
    running_xor_next = running_xor;
    tick_count_next  = tick_count;
    if (is_tick) begin
      if (phase == PH_BODY) begin
        tick_count_next = tick_inc;
        if (timeout_hit) begin
          phase_next       = PH_HEADER;
          index_count_next = '0;
          frame_total_next = HDR_LEN;
          running_xor_next = '0;
          tick_count_next  = '0;
        end
      end
    end else if (phase == PH_HEADER) begin
      first_byte_next  = first_cur;
      length_byte_next = len_cur;
      running_xor_next = (index_count == 9'd0) ? 8'h00 : running_xor ^ rx_byte;
      index_count_next = idx_inc;
      if (bad_start || too_long) begin
        index_count_next = '0;
        frame_total_next = HDR_LEN;
        running_xor_next = '0;
        tick_count_next  = '0;
      end else if (hdr_done) begin
        phase_next       = PH_BODY;
        frame_total_next = total;
        tick_count_next  = '0;
      end
    end else begin
      if (last_byte) begin
        phase_next       = PH_HEADER;
        index_count_next = '0;
        frame_total_next = HDR_LEN;
        running_xor_next = '0;
        tick_count_next  = '0;
      end else begin
        running_xor_next = running_xor ^ rx_byte;
        index_count_next = idx_inc;
      end
    end
  end

  // result of this word
  always_comb begin
    res.byte_out      = is_byte ? rx_byte : 8'h00;
    res.byte_index    = is_byte ? index_count : 9'd0;
    res.byte_taken    = is_byte;
    res.frame_end     = last_byte;
    res.checksum_good = last_byte && sum_match;
    priority if (timeout_hit)            res.error_kind = ERR_TIMEOUT;
    else if (bad_start)                  res.error_kind = ERR_BAD_START;
    else if (too_long)                   res.error_kind = ERR_TOO_LONG;
    else if (last_byte && !sum_match)    res.error_kind = ERR_CHECKSUM;
    else                                 res.error_kind = ERR_NONE;
    res.wake_line     = (phase_next == PH_HEADER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      index_count <= '0;
      frame_total <= HDR_LEN;
      first_byte  <= '0;
      length_byte <= '0;
      running_xor <= '0;
      tick_count  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      index_count <= index_count_next;
      frame_total <= frame_total_next;
      first_byte  <= first_byte_next;
      length_byte <= length_byte_next;
      running_xor <= running_xor_next;
      tick_count  <= tick_count_next;
    end
  end

endmodule

[verif/tb_serial_frame_receiver_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_frame_receiver_unit
// self-checking bench for the serial frame receiver: directed frames for the
// error kinds and the body timeout, then random frames under several register
// settings, with random gaps on the input and random stalls on the output;
// every result word is checked field by field against a frame tracker
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver_unit;
  import sfr_pkg::*;

  localparam int HDR         = HEADER_BYTES_DEFAULT;
  localparam int QUIET_LIMIT = 4000;   // cycles with no word moving on either side

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action   = ACT_BYTE;
  logic [7:0] rx_byte  = 8'h00;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] byte_out;
  logic [8:0] byte_index;
  logic       byte_taken;
  logic       frame_end;
  logic       checksum_good;
  logic [2:0] error_kind;
  logic       wake_line;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  serial_frame_receiver_unit #(.HEADER_BYTES(HDR)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .byte_out(byte_out),
    .byte_index(byte_index), .byte_taken(byte_taken), .frame_end(frame_end),
    .checksum_good(checksum_good), .error_kind(error_kind), .wake_line(wake_line),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // --------------------------------------------------------------------------
  // frame tracker: mirrors the deframer state and register values, queues the
  // result word each accepted input word must produce
  // --------------------------------------------------------------------------
  class frame_tracker;
    result_t     expected_q[$];
    int unsigned mismatches;

    logic [7:0]  start_val;
    logic [8:0]  limit_val;
    logic [15:0] timeout_val;

    phase_t      ph;
    logic [8:0]  pos;
    logic [8:0]  total;
    logic [7:0]  first;
    logic [7:0]  len;
    logic [7:0]  xsum;
    logic [16:0] ticks;

    function new();
      mismatches  = 0;
      start_val   = START_BYTE_RESET;
      limit_val   = FRAME_LIMIT_RESET;
      timeout_val = TIMEOUT_TICKS_RESET;
      first       = 8'h00;
      len         = 8'h00;
      restart();
    endfunction

    // drop whatever frame is in progress and wait for a new header
    function void restart();
      ph    = PH_HEADER;
      pos   = 9'd0;
      total = 9'(HDR);
      xsum  = 8'h00;
      ticks = 17'd0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] v);
      case (idx)
        REG_START_BYTE:    start_val   = v[7:0];
        REG_FRAME_LIMIT:   limit_val   = v[8:0];
        REG_TIMEOUT_TICKS: timeout_val = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic act, logic [7:0] b);
      result_t     r;
      int unsigned sum;
      r = '0;
      r.error_kind = ERR_NONE;
      if (act == ACT_TICK) begin
        // ticks only matter while a body is being collected
        if (ph == PH_BODY) begin
          if (ticks != TICK_MAX) ticks = ticks + 17'd1;
          if (ticks > {1'b0, timeout_val}) begin
            r.error_kind = ERR_TIMEOUT;
            restart();
          end
        end
      end else begin
        r.byte_out   = b;
        r.byte_index = pos;
        r.byte_taken = 1'b1;
        if (ph == PH_HEADER) begin
          if (pos == 9'd0) begin
            first = b;
            xsum  = 8'h00;
          end else begin
            xsum = xsum ^ b;
          end
          if (pos == 9'd1) len = b;
          pos = pos + 9'd1;
          if (pos >= 9'(HDR)) begin
            sum = len + HDR + 1;
            // start byte is judged before the length
            if (first != start_val) begin
              r.error_kind = ERR_BAD_START;
              restart();
            end else if (sum > limit_val) begin
              r.error_kind = ERR_TOO_LONG;
              restart();
            end else begin
              ph    = PH_BODY;
              total = 9'(sum);
              ticks = 17'd0;
            end
          end
        end else begin
          if (32'(pos) + 1 >= 32'(total)) begin
            // checksum byte closes the frame
            r.frame_end = 1'b1;
            if (xsum == b) r.checksum_good = 1'b1;
            else r.error_kind = ERR_CHECKSUM;
            restart();
          end else begin
            xsum = xsum ^ b;
            pos  = pos + 9'd1;
          end
        end
      end
      r.wake_line = (ph == PH_HEADER);
      expected_q.push_back(r);
    endfunction

    function void report(string name, logic [8:0] exp_v, logic [8:0] got_v);
      if (got_v !== exp_v) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: result word with none expected, byte_out %0h index %0h",
                   $time, got.byte_out, got.byte_index);
        return;
      end
      e = expected_q.pop_front();
      report("byte_out",      9'(e.byte_out),      9'(got.byte_out));
      report("byte_index",    e.byte_index,        got.byte_index);
      report("byte_taken",    9'(e.byte_taken),    9'(got.byte_taken));
      report("frame_end",     9'(e.frame_end),     9'(got.frame_end));
      report("checksum_good", 9'(e.checksum_good), 9'(got.checksum_good));
      report("error_kind",    9'(e.error_kind),    9'(got.error_kind));
      report("wake_line",     9'(e.wake_line),     9'(got.wake_line));
    endfunction
  endclass

  frame_tracker tracker;
  int unsigned  words_sent  = 0;
  int unsigned  quiet_cycles = 0;
  bit           calm = 1'b0;    // when set, neither side idles
  int unsigned  stall_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // monitor: both channels sampled on the same edge, input noted before the
  // result check; also feeds the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tracker.note_word(action, rx_byte);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.byte_out      = byte_out;
        got.byte_index    = byte_index;
        got.byte_taken    = byte_taken;
        got.frame_end     = frame_end;
        got.checksum_good = checksum_good;
        got.error_kind    = err_kind_t'(error_kind);
        got.wake_line     = wake_line;
        tracker.check_result(got);
        moved = 1'b1;
      end
    end
    quiet_cycles <= (rst || moved) ? 0 : quiet_cycles + 1;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // output backpressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      out_stall <= 1'b1;
      stall_left = idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: nothing moving for too long means the block hung
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("** serial_frame_receiver_unit: FAILED **");
    $finish;
  end

  // one input word; valid stays high across back-to-back words
  task automatic send_word(input logic act, input logic [7:0] b);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // hold the sender until every expected result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, v);
    // the bus idles before the next setup
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] sb, input logic [8:0] lim,
                             input logic [15:0] tmo);
    drain();
    write_reg(REG_START_BYTE,    PDATA_W'(sb));
    write_reg(REG_FRAME_LIMIT,   PDATA_W'(lim));
    write_reg(REG_TIMEOUT_TICKS, PDATA_W'(tmo));
  endtask

  // one frame with random content; sometimes a wrong start byte, a length
  // over the limit, a tick burst in the body, a cut-off body or a bad checksum
  task automatic send_frame();
    int unsigned roomy, flen, cut, i, r;
    logic [7:0]  head, xs, b;
    roomy = (tracker.limit_val > 9'd5) ? tracker.limit_val - 5 : 0;
    if (roomy > 255) roomy = 255;
    head = ($urandom_range(0, 99) < 7) ? 8'($urandom) : tracker.start_val;
    r = $urandom_range(0, 99);
    if (r < 8 && roomy < 255) flen = $urandom_range(roomy + 1, 255);
    else if (r < 80) flen = $urandom_range(0, (roomy < 12) ? roomy : 12);
    else if (r < 94) flen = $urandom_range(0, roomy);
    else flen = roomy;   // largest frame the limit allows
    cut = ($urandom_range(0, 99) < 5) ? $urandom_range(0, flen) : flen + 1;
    send_word(ACT_BYTE, head);
    xs = 8'(flen);
    send_word(ACT_BYTE, 8'(flen));
    repeat (2) begin
      b  = 8'($urandom);
      xs = xs ^ b;
      send_word(ACT_BYTE, b);
    end
    if ($urandom_range(0, 99) < 6)
      repeat ($urandom_range(1, 24)) send_word(ACT_TICK, 8'($urandom));
    for (i = 0; i < flen; i++) begin
      if (i == cut) return;
      if ($urandom_range(0, 99) < 4) send_word(ACT_TICK, 8'($urandom));
      b  = 8'($urandom);
      xs = xs ^ b;
      send_word(ACT_BYTE, b);
    end
    if ($urandom_range(0, 99) < 12) xs = xs ^ 8'($urandom_range(1, 255));
    send_word(ACT_BYTE, xs);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 99) < 4) calm = ~calm;
      if ($urandom_range(0, 199) == 0) drain();
      if ($urandom_range(0, 99) < 80) send_frame();
      else send_word(1'($urandom_range(0, 1)), 8'($urandom));
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, register reset values
    send_word(ACT_TICK, 8'hFF);            // tick while waiting for a header
    send_word(ACT_BYTE, 8'h55);            // empty frame, extreme byte values
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'hFF);
    send_word(ACT_BYTE, 8'hFF);            // checksum 00 ^ 00 ^ ff
    send_word(ACT_BYTE, 8'hAA);            // bad start and too long at once:
    send_word(ACT_BYTE, 8'hFF);            // bad start must win
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'h55);            // length 124 gives 129 bytes, over 128
    send_word(ACT_BYTE, 8'h7C);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'h55);            // one payload byte, wrong checksum
    send_word(ACT_BYTE, 8'h01);
    send_word(ACT_BYTE, 8'h12);
    send_word(ACT_BYTE, 8'h34);
    send_word(ACT_BYTE, 8'h56);
    send_word(ACT_BYTE, 8'h8E);            // correct would be 71

    // body timeout: second tick goes past a one-tick allowance
    reconfigure(START_BYTE_RESET, FRAME_LIMIT_RESET, 16'd1);
    send_word(ACT_BYTE, 8'h55);
    send_word(ACT_BYTE, 8'h03);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_BYTE, 8'h00);
    send_word(ACT_TICK, 8'h00);
    send_word(ACT_TICK, 8'h00);

    // random part over several register settings, extremes included
    reconfigure(8'h00, 9'd5, 16'd1);
    run_random(300);
    reconfigure(8'hFF, 9'd260, 16'd65535);
    run_random(450);
    reconfigure(8'hA5, 9'd40, 16'd12);
    run_random(350);
    reconfigure(8'($urandom), 9'($urandom_range(5, 260)), 16'($urandom_range(1, 30)));
    run_random(350);
    reconfigure(START_BYTE_RESET, FRAME_LIMIT_RESET, TIMEOUT_TICKS_RESET);
    run_random(470);

    // let the pipeline settle so stray result words get caught
    drain();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
      $display("** serial_frame_receiver_unit: PASSED **");
    else
      $display("** serial_frame_receiver_unit: FAILED **");
    $finish;
  end

endmodule
